### rtl/afr_pkg.sv
// afr_pkg: shared types and constants for the API frame receiver.
// Holds frame codes, the parser phase encoding and the decoded result record.
// No dependencies.
package afr_pkg;

  // Framing and frame type codes
  localparam logic [7:0] DELIM        = 8'h7E;
  localparam logic [7:0] SUM_INIT     = 8'hFF;
  localparam logic [7:0] T_AT_RESP    = 8'h88;
  localparam logic [7:0] T_MODEM      = 8'h8A;
  localparam logic [7:0] T_TX_STATUS  = 8'h8B;
  localparam logic [7:0] MODEM_JOINED = 8'h02;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_I       = 8'h49;

  // Number of leading body bytes that are captured
  localparam int unsigned NCAP = 6;

  // Offset of the first data byte in an AT response body
  localparam logic [15:0] AT_HDR_LEN = 16'd5;

  typedef logic [NCAP-1:0][7:0] afr_caps_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_LENHI = 5'b00010,
    PH_LENLO = 5'b00100,
    PH_BODY  = 5'b01000,
    PH_CKSUM = 5'b10000
  } afr_phase_e;

  // Decoded frame record
  typedef struct packed {
    logic        frame_valid;
    logic        checksum_good;
    logic [7:0]  frame_type;
    logic [7:0]  frame_ident;
    logic [7:0]  command_first;
    logic [7:0]  command_second;
    logic [7:0]  status_code;
    logic [15:0] data_count;
    logic [7:0]  first_data;
    logic        joined;
  } afr_result_t;

endpackage

### rtl/afr_if.sv
// afr_if: valid/ready channel interfaces of the API frame receiver.
// afr_rx_if carries received bytes, afr_res_if carries decoded frames.
// No dependencies.
interface afr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_res_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic        checksum_good;
  logic [7:0]  frame_type;
  logic [7:0]  frame_ident;
  logic [7:0]  command_first;
  logic [7:0]  command_second;
  logic [7:0]  status_code;
  logic [15:0] data_count;
  logic [7:0]  first_data;
  logic        joined;

  modport source (
    output valid, output frame_valid, output checksum_good, output frame_type,
    output frame_ident, output command_first, output command_second,
    output status_code, output data_count, output first_data, output joined,
    input ready
  );
  modport sink (
    input valid, input frame_valid, input checksum_good, input frame_type,
    input frame_ident, input command_first, input command_second,
    input status_code, input data_count, input first_data, input joined,
    output ready
  );
endinterface

### rtl/afr_decode.sv
// afr_decode: combinational decode of a finished frame at its checksum byte.
// Builds the result record and the next association flag.
// Depends on afr_pkg.
module afr_decode (
  input  afr_pkg::afr_caps_t   caps_i,
  input  logic [15:0]          body_length_i,
  input  logic [7:0]           running_sum_i,
  input  logic [7:0]           cksum_i,
  input  logic                 assoc_i,
  output afr_pkg::afr_result_t res_o,
  output logic                 assoc_o
);
  import afr_pkg::*;

  logic [7:0]  ftype;
  logic        good;
  logic        is_at;
  logic        is_modem;
  logic        is_tx;
  logic        valid;
  logic [15:0] count;
  logic [7:0]  status;
  logic [7:0]  first;
  logic        ai_join;

  // Frame type and checksum check
  assign ftype    = (body_length_i != 16'd0) ? caps_i[0] : 8'h00;
  assign good     = (cksum_i == running_sum_i);
  assign is_at    = (ftype == T_AT_RESP);
  assign is_modem = (ftype == T_MODEM);
  assign is_tx    = (ftype == T_TX_STATUS);
  assign valid    = good && (is_at || is_modem || is_tx);

  // Data byte count of an AT response, floored at zero
  assign count = (is_at && (body_length_i > AT_HDR_LEN)) ?
                 (body_length_i - AT_HDR_LEN) : 16'd0;
  assign first = (is_at && (count != 16'd0)) ? caps_i[5] : 8'h00;

  // Status byte position depends on frame type
  always_comb begin
    status = 8'h00;
    if (is_at) begin
      status = caps_i[4];
    end else if (is_modem) begin
      status = caps_i[1];
    end else if (is_tx) begin
      status = caps_i[5];
    end
  end

  // AI reply with association indication zero means joined
  assign ai_join = (caps_i[2] == CHAR_A) && (caps_i[3] == CHAR_I) &&
                   (status == 8'h00) && (count != 16'd0) && (first == 8'h00);

  // Association update, only on good known frames
  always_comb begin
    assoc_o = assoc_i;
    if (valid && is_modem) begin
      assoc_o = (status == MODEM_JOINED);
    end else if (valid && is_at && ai_join) begin
      assoc_o = 1'b1;
    end
  end

  always_comb begin
    res_o.frame_valid    = valid;
    res_o.checksum_good  = good;
    res_o.frame_type     = ftype;
    res_o.frame_ident    = is_at ? caps_i[1] : 8'h00;
    res_o.command_first  = is_at ? caps_i[2] : 8'h00;
    res_o.command_second = is_at ? caps_i[3] : 8'h00;
    res_o.status_code    = status;
    res_o.data_count     = count;
    res_o.first_data     = first;
    res_o.joined         = assoc_o;
  end

endmodule

### rtl/api_frame_receiver.sv
// api_frame_receiver: top level of the API-mode frame receiver.
// Depends on afr_pkg, afr_if (afr_rx_if, afr_res_if) and afr_decode.
//
// Takes one received serial byte per transaction and emits one decoded frame
// record per frame, on the transaction that carries the checksum byte. A byte
// is registered on entry and then processed by the frame parser, whose result
// lands in an output register; the block takes one byte every cycle unless it
// is held back. Bytes are only held back while a finished frame waits in the
// output register and the next checksum byte is ready to be processed. Bytes
// outside a frame are dropped until the 0x7E delimiter arrives; there is no
// escaping, and the association flag survives across frames.
module api_frame_receiver (
  input logic clk_i,
  input logic rst_ni,
  afr_rx_if.sink    rx_i,
  afr_res_if.source res_o
);
  import afr_pkg::*;

  // Input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       emit;

  // Parser state
  afr_phase_e  phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  afr_caps_t   caps_q, caps_d;
  logic        assoc_q, assoc_d;
  logic [16:0] idx_inc;

  // Output register
  logic        out_v_q;
  afr_result_t res_q;
  afr_result_t dec_res;
  logic        dec_assoc;

  // Byte moves into the parser when it produces nothing or the output is free
  assign emit     = in_v_q && (phase_q == PH_CKSUM);
  assign fire     = in_v_q && ((phase_q != PH_CKSUM) || !out_v_q || res_o.ready);
  assign rx_i.ready = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_v_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  afr_decode u_decode (
    .caps_i        (caps_q),
    .body_length_i (len_q),
    .running_sum_i (sum_q),
    .cksum_i       (in_byte_q),
    .assoc_i       (assoc_q),
    .res_o         (dec_res),
    .assoc_o       (dec_assoc)
  );

  assign idx_inc = {1'b0, idx_q} + 17'd1;

  // Frame parser next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    caps_d  = caps_q;
    assoc_d = assoc_q;
    case (phase_q)
      PH_LENHI: begin
        len_d   = {in_byte_q, 8'h00};
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len_d   = {len_q[15:8], in_byte_q};
        idx_d   = 16'd0;
        sum_d   = SUM_INIT;
        caps_d  = '0;
        phase_d = ({len_q[15:8], in_byte_q} == 16'd0) ? PH_CKSUM : PH_BODY;
      end
      PH_BODY: begin
        for (int i = 0; i < NCAP; i++) begin
          if (idx_q == 16'(i)) begin
            caps_d[i] = in_byte_q;
          end
        end
        sum_d = sum_q - in_byte_q;
        idx_d = idx_inc[15:0];
        if (idx_inc >= {1'b0, len_q}) begin
          phase_d = PH_CKSUM;
        end
      end
      PH_CKSUM: begin
        assoc_d = dec_assoc;
        phase_d = PH_HUNT;
      end
      default: begin
        // hunting, and any code with no meaning
        phase_d = (in_byte_q == DELIM) ? PH_LENHI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 16'd0;
      idx_q   <= 16'd0;
      sum_q   <= SUM_INIT;
      caps_q  <= '0;
      assoc_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      caps_q  <= caps_d;
      assoc_q <= assoc_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && emit) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= dec_res;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.frame_valid    = res_q.frame_valid;
  assign res_o.checksum_good  = res_q.checksum_good;
  assign res_o.frame_type     = res_q.frame_type;
  assign res_o.frame_ident    = res_q.frame_ident;
  assign res_o.command_first  = res_q.command_first;
  assign res_o.command_second = res_q.command_second;
  assign res_o.status_code    = res_q.status_code;
  assign res_o.data_count     = res_q.data_count;
  assign res_o.first_data     = res_q.first_data;
  assign res_o.joined         = res_q.joined;

  // A checksum byte that is processed always yields a result next cycle
  a_emit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_v_q)
    else $error("checksum byte processed without a result");

  // The association flag moves only when a frame finishes
  a_assoc_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && emit) |=> (assoc_q == $past(assoc_q)))
    else $error("association changed outside a frame end");

  // A frame body phase never runs with a zero length
  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (len_q != 16'd0) && (idx_q < len_q))
    else $error("body phase with exhausted length");

  // A valid frame needs a good checksum; data count only for AT responses
  a_res_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!res_q.frame_valid || res_q.checksum_good) &&
                ((res_q.data_count == 16'd0) || (res_q.frame_type == T_AT_RESP)))
    else $error("inconsistent result record");

  // The joined flag in a result matches the live association flag
  a_res_joined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> (res_q.joined == assoc_q))
    else $error("result joined flag disagrees with state");

endmodule

### tb/api_frame_receiver_tb.sv
// api_frame_receiver_tb: self-checking testbench for the API frame receiver.
// Streams framed and stray bytes in, decodes them in a local frame decoder and
// compares every decoded record. Depends on afr_pkg, afr_if and api_frame_receiver.
module api_frame_receiver_tb;
  import afr_pkg::*;

  typedef logic [7:0] byte_list_t[$];

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned HOLDOFF_LEN  = 60;
  localparam int unsigned HOLDOFF_AT   = 20;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  afr_rx_if  rx_if();
  afr_res_if res_if();

  api_frame_receiver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Pending serial bytes and decoded frames still to arrive
  logic [7:0]  byte_q[$];
  afr_result_t frame_q[$];

  // Decoder state, mirrors the receiver after reset
  afr_phase_e  dec_phase = PH_HUNT;
  logic [15:0] dec_len = '0;
  logic [15:0] dec_idx = '0;
  logic [7:0]  dec_sum = SUM_INIT;
  logic [7:0]  dec_caps [NCAP] = '{default: 8'h00};
  logic        dec_joined = 1'b0;

  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_got = 0;
  int unsigned frames_good = 0;
  int unsigned joined_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holdoff_left = 0;
  bit          held_off = 1'b0;
  afr_result_t next_frame;

  always #10 clk_i = ~clk_i;

  // Decode one received byte; returns 1 when it closes a frame
  function automatic bit decode_byte(input logic [7:0] b, output afr_result_t r);
    logic [7:0]  ftype;
    logic [15:0] cnt;
    logic [7:0]  first;
    bit          good;
    bit          closed;
    r = '0;
    closed = 1'b0;
    case (dec_phase)
      PH_LENHI: begin
        dec_len = {b, 8'h00};
        dec_phase = PH_LENLO;
      end
      PH_LENLO: begin
        dec_len = {dec_len[15:8], b};
        dec_idx = '0;
        dec_sum = SUM_INIT;
        dec_caps = '{default: 8'h00};
        dec_phase = (dec_len == 16'd0) ? PH_CKSUM : PH_BODY;
      end
      PH_BODY: begin
        if (dec_idx < NCAP) dec_caps[dec_idx[2:0]] = b;
        dec_sum = dec_sum - b;
        dec_idx = dec_idx + 16'd1;
        if (dec_idx >= dec_len) dec_phase = PH_CKSUM;
      end
      PH_CKSUM: begin
        ftype = (dec_len >= 16'd1) ? dec_caps[0] : 8'h00;
        good = (b == dec_sum);
        cnt = '0;
        first = '0;
        r.checksum_good = good;
        r.frame_type = ftype;
        r.frame_valid = good && (ftype inside {T_AT_RESP, T_MODEM, T_TX_STATUS});
        case (ftype)
          T_AT_RESP: begin
            cnt = (dec_len > AT_HDR_LEN) ? dec_len - AT_HDR_LEN : 16'd0;
            if (cnt >= 16'd1) first = dec_caps[5];
            r.frame_ident = dec_caps[1];
            r.command_first = dec_caps[2];
            r.command_second = dec_caps[3];
            r.status_code = dec_caps[4];
            r.data_count = cnt;
            r.first_data = first;
          end
          T_MODEM:     r.status_code = dec_caps[1];
          T_TX_STATUS: r.status_code = dec_caps[5];
          default: ;
        endcase
        // Association only moves on a valid modem status or AI reply
        if (r.frame_valid) begin
          if (ftype == T_MODEM) begin
            dec_joined = (r.status_code == MODEM_JOINED);
          end else if (ftype == T_AT_RESP && r.command_first == CHAR_A &&
                       r.command_second == CHAR_I && r.status_code == 8'h00 &&
                       cnt >= 16'd1 && first == 8'h00) begin
            dec_joined = 1'b1;
          end
        end
        r.joined = dec_joined;
        dec_phase = PH_HUNT;
        closed = 1'b1;
      end
      default: dec_phase = (b == DELIM) ? PH_LENHI : PH_HUNT;
    endcase
    return closed;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  // Delimiter, big-endian length, body, checksum (optionally corrupted)
  task automatic queue_frame(input byte_list_t body, input bit bad_sum);
    logic [7:0]  sum;
    logic [15:0] len;
    sum = SUM_INIT;
    len = 16'(body.size());
    push_byte(DELIM);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    foreach (body[i]) begin
      push_byte(body[i]);
      sum = sum - body[i];
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  // Mostly well-formed frames of the three known kinds, plus junk
  task automatic queue_random_frame();
    byte_list_t  body;
    int unsigned len;
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    int unsigned i;
    logic [7:0]  nb;
    kind = $urandom_range(99);
    r = $urandom_range(99);
    if (kind < 40) begin
      len = (r < 5)  ? $urandom_range(1, 4) :
            (r < 90) ? $urandom_range(5, 8) :
            (r < 97) ? $urandom_range(9, 20) : $urandom_range(200, 300);
    end else if (kind < 65) begin
      len = (r < 80) ? 2 : $urandom_range(1, 8);
    end else if (kind < 85) begin
      len = (r < 75) ? 7 : $urandom_range(1, 10);
    end else if (kind < 94) begin
      len = $urandom_range(0, 8);
    end else begin
      len = 0;
    end
    for (i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
    if (len > 0) begin
      if (kind < 40) begin
        body[0] = T_AT_RESP;
        if (len > 3 && $urandom_range(1)) begin
          body[2] = CHAR_A;
          body[3] = CHAR_I;
        end
        if (len > 4 && $urandom_range(1)) body[4] = 8'h00;
        if (len > 5 && $urandom_range(1)) body[5] = 8'h00;
      end else if (kind < 65) begin
        body[0] = T_MODEM;
        if (len > 1 && $urandom_range(1)) body[1] = MODEM_JOINED;
      end else if (kind < 85) begin
        body[0] = T_TX_STATUS;
      end
    end
    // Line noise between frames, kept free of delimiters
    if ($urandom_range(99) < 30) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        nb = 8'($urandom_range(255));
        if (nb == DELIM) nb = 8'h00;
        push_byte(nb);
      end
    end
    queue_frame(body, $urandom_range(99) < 12);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < count) queue_random_frame();
  endtask

  // Sender stays silent until every decoded frame is back
  task automatic wait_drained();
    while (byte_q.size() != 0 || rx_if.valid || frame_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Byte driver: holds a byte until accepted, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= 8'h00;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        if (decode_byte(rx_if.rx_byte, next_frame)) frame_q.push_back(next_frame);
        bytes_sent++;
      end
      if (rx_if.valid && !rx_if.ready) begin
        stall_cycles++;
      end else if (byte_q.size() != 0 &&
                   ((bytes_sent >= 250 && bytes_sent < 400) ||
                    $urandom_range(99) >= IDLE_PCT)) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= byte_q.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'($urandom_range(255));
      end
    end
  end

  // Result monitor: checks each decoded frame, throttles ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        frames_got++;
        if (res_if.joined === 1'b1) joined_seen++;
        if (res_if.frame_valid === 1'b1) frames_good++;
        if (frame_q.size() == 0) begin
          $error("decoded frame arrived with none pending: type %0h", res_if.frame_type);
          mismatches++;
        end else begin
          next_frame = frame_q.pop_front();
          check_field("frame_valid", 16'(next_frame.frame_valid),
                      16'(res_if.frame_valid));
          check_field("checksum_good", 16'(next_frame.checksum_good),
                      16'(res_if.checksum_good));
          check_field("frame_type", 16'(next_frame.frame_type),
                      16'(res_if.frame_type));
          check_field("frame_ident", 16'(next_frame.frame_ident),
                      16'(res_if.frame_ident));
          check_field("command_first", 16'(next_frame.command_first),
                      16'(res_if.command_first));
          check_field("command_second", 16'(next_frame.command_second),
                      16'(res_if.command_second));
          check_field("status_code", 16'(next_frame.status_code),
                      16'(res_if.status_code));
          check_field("data_count", next_frame.data_count, res_if.data_count);
          check_field("first_data", 16'(next_frame.first_data),
                      16'(res_if.first_data));
          check_field("joined", 16'(next_frame.joined), 16'(res_if.joined));
        end
      end
      // One long hold-off so the receiver backs up into the input
      if (!held_off && frames_got >= HOLDOFF_AT) begin
        held_off = 1'b1;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= (frames_got >= 40 && frames_got < 55) ||
                        ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus sequence and end of run
  initial begin
    byte_list_t body;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Stray byte, then an empty frame with the all-ones checksum
    push_byte(8'h00);
    body = {};
    queue_frame(body, 1'b0);
    // Modem status reporting association
    body = {T_MODEM, MODEM_JOINED};
    queue_frame(body, 1'b0);
    // AI reply with zero data byte
    body = {T_AT_RESP, 8'h01, CHAR_A, CHAR_I, 8'h00, 8'h00};
    queue_frame(body, 1'b0);
    // Short transmit status carrying a delimiter, bad checksum
    body = {T_TX_STATUS, DELIM};
    queue_frame(body, 1'b1);
    wait_drained();

    queue_random(350);
    wait_drained();
    queue_random(350);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d bytes sent, %0d frames decoded (%0d valid, %0d with joined set)",
             bytes_sent, frames_got, frames_good, joined_seen);
    $display("summary: %0d input stall cycles, %0d mismatches", stall_cycles, mismatches);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
